// ----- hdl/hmdu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmdu_pkg
// Shared types and operation codes of the HI/LO multiply-divide unit.
// ----------------------------------------------------------------------------
package hmdu_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 3;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_MULT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MULTU = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DIV   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIVU  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MTHI  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MTLO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_MFHI  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_MFLO  = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] rs_value;
        logic [WORD_W-1:0] rt_value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [WORD_W-1:0] hi_after;
        logic [WORD_W-1:0] lo_after;
    } rsp_t;

endpackage

// ----- hdl/hmdu_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmdu_req_if
// Request channel: valid/ready handshake carrying one operation.
// ----------------------------------------------------------------------------
interface hmdu_req_if;
    import hmdu_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/hmdu_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmdu_rsp_if
// Response channel: valid/ready handshake carrying one result.
// ----------------------------------------------------------------------------
interface hmdu_rsp_if;
    import hmdu_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/hilo_multiply_divide_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilo_multiply_divide_unit
// HI/LO multiply-divide unit with a bit-serial shift-add multiplier and a
// restoring divider sharing one 64-bit shift register.
// ----------------------------------------------------------------------------
// sequence: multiply and divide load their operands at accept, then run
//   32 serial steps, one sign fix and a write-back that registers the result
// move operations go from accept straight to write-back; one transaction is in flight at a time
// write-back waits while an earlier result is still held on the response
//   channel; a waiting result does not block the next accept
// reset: HI, LO, the state and the result valid flag clear to zero asynchronously
module hilo_multiply_divide_unit (
    input  logic        clk,
    input  logic        rst_n,
    hmdu_req_if.sink    req,
    hmdu_rsp_if.source  rsp
);
    import hmdu_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIX  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [2*WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0]   opnd_reg, opnd_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                neg_hi_reg, neg_hi_next;
    logic                neg_lo_reg, neg_lo_next;
    logic [WORD_W-1:0]   hi_reg, hi_next;
    logic [WORD_W-1:0]   lo_reg, lo_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_reg, out_next;

    logic                in_fire;
    logic                fin_fire;
    logic                is_signed;
    logic                rs_neg;
    logic                rt_neg;
    logic [WORD_W-1:0]   rs_mag;
    logic [WORD_W-1:0]   rt_mag;
    logic [WORD_W:0]     mul_sum;
    logic [WORD_W+1:0]   div_diff;
    logic                div_ok;

    assign req.ready = (state_reg == ST_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign fin_fire  = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // operand magnitudes for the signed forms
    always_comb
    begin
        is_signed = (req.payload.kind == KIND_MULT) || (req.payload.kind == KIND_DIV);
        rs_neg    = is_signed && req.payload.rs_value[WORD_W-1];
        rt_neg    = is_signed && req.payload.rt_value[WORD_W-1];
        rs_mag    = rs_neg ? (~req.payload.rs_value + WORD_W'(1)) : req.payload.rs_value;
        rt_mag    = rt_neg ? (~req.payload.rt_value + WORD_W'(1)) : req.payload.rt_value;
    end

    // one shift-add step and one restoring divide step
    always_comb
    begin
        mul_sum  = {1'b0, acc_reg[2*WORD_W-1:WORD_W]}
                 + (acc_reg[0] ? {1'b0, opnd_reg} : {(WORD_W+1){1'b0}});
        div_diff = {1'b0, acc_reg[2*WORD_W-1:WORD_W], acc_reg[WORD_W-1]}
                 - {2'b00, opnd_reg};
        div_ok   = !div_diff[WORD_W+1];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        opnd_next      = opnd_reg;
        kind_next      = kind_reg;
        neg_hi_next    = neg_hi_reg;
        neg_lo_next    = neg_lo_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next = req.payload.kind;
                    cnt_next  = {CNT_W{1'b1}};
                    case (req.payload.kind)
                        KIND_MULT, KIND_MULTU:
                        begin
                            acc_next    = {{WORD_W{1'b0}}, rt_mag};
                            opnd_next   = rs_mag;
                            neg_hi_next = rs_neg ^ rt_neg;
                            neg_lo_next = rs_neg ^ rt_neg;
                            state_next  = ST_MUL;
                        end
                        KIND_DIV, KIND_DIVU:
                        begin
                            acc_next    = {{WORD_W{1'b0}}, rs_mag};
                            opnd_next   = rt_mag;
                            neg_hi_next = rs_neg;
                            neg_lo_next = rs_neg ^ rt_neg;
                            state_next  = ST_DIV;
                        end
                        default:
                        begin
                            opnd_next  = req.payload.rs_value;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                acc_next = {mul_sum, acc_reg[WORD_W-1:1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_DIV:
            begin
                // keep the shifted remainder when the divisor does not fit
                acc_next = {div_ok ? div_diff[WORD_W-1:0] : acc_reg[2*WORD_W-2:WORD_W-1],
                            acc_reg[WORD_W-2:0], div_ok};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                // restore signs: whole product, or remainder and quotient apart
                if ((kind_reg == KIND_MULT) || (kind_reg == KIND_MULTU))
                begin
                    if (neg_lo_reg)
                    begin
                        acc_next = ~acc_reg + (2*WORD_W)'(1);
                    end
                end
                else
                begin
                    if (neg_hi_reg)
                    begin
                        acc_next[2*WORD_W-1:WORD_W] = ~acc_reg[2*WORD_W-1:WORD_W]
                                                    + WORD_W'(1);
                    end
                    if (neg_lo_reg)
                    begin
                        acc_next[WORD_W-1:0] = ~acc_reg[WORD_W-1:0] + WORD_W'(1);
                    end
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_fire)
                begin
                    out_next.read_value = '0;
                    case (kind_reg)
                        KIND_MULT, KIND_MULTU, KIND_DIV, KIND_DIVU:
                        begin
                            hi_next = acc_reg[2*WORD_W-1:WORD_W];
                            lo_next = acc_reg[WORD_W-1:0];
                        end
                        KIND_MTHI: hi_next = opnd_reg;
                        KIND_MTLO: lo_next = opnd_reg;
                        KIND_MFHI: out_next.read_value = hi_reg;
                        default:   out_next.read_value = lo_reg;
                    endcase
                    out_next.hi_after = hi_next;
                    out_next.lo_after = lo_next;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        opnd_reg   <= opnd_next;
        kind_reg   <= kind_next;
        neg_hi_reg <= neg_hi_next;
        neg_lo_reg <= neg_lo_next;
        out_reg    <= out_next;
    end

    // serial loop hands over to the sign fix after its last step
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL) || (state_reg == ST_DIV)) && (cnt_reg == '0)
        |=> (state_reg == ST_FIX))
        else $error("serial loop did not end after last step");

    // a move transaction goes straight to write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && ((req.payload.kind == KIND_MTHI) || (req.payload.kind == KIND_MTLO)
                 || (req.payload.kind == KIND_MFHI) || (req.payload.kind == KIND_MFLO))
        |=> (state_reg == ST_FIN))
        else $error("move transaction did not reach write-back");

    // a new result only appears out of write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result valid raised outside write-back");

    // hi/lo change only at write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FIN) |=> ($stable(hi_reg) && $stable(lo_reg)))
        else $error("hi/lo changed outside write-back");

endmodule

// ----- tb/hilo_multiply_divide_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilo_multiply_divide_unit_test
// Self-checking bench for the HI/LO multiply-divide unit. Directed corner
// operations and then random operations are sent with random gaps. Results
// are drained under random backpressure and checked field by field against
// a HI/LO model that is updated as each request is accepted.
// ----------------------------------------------------------------------------
module hilo_multiply_divide_unit_test;
    import hmdu_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_OPS   = 1600;
    localparam int SETTLE_WAIT  = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    localparam logic [WORD_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] SIGN_WORD = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MAX_POS   = 32'h7FFF_FFFF;

    typedef struct {
        req_t op;
        bit   drain_first;
    } pending_op_t;

    logic clk;
    logic rst_n;

    hmdu_req_if req_if ();
    hmdu_rsp_if rsp_if ();

    hilo_multiply_divide_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    pending_op_t       pending_ops[$];
    rsp_t              expected_results[$];
    logic [WORD_W-1:0] hi_model = '0;
    logic [WORD_W-1:0] lo_model = '0;
    int                send_gap;
    int                stall_left;
    int                accepted_count;
    int                checked_count;
    int                mismatch_count;
    int                cycle_count;

    // clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // HI/LO model: applies one operation and returns the result it should give
    function automatic rsp_t hilo_predict(req_t op);
        logic [63:0]       product;
        logic [WORD_W-1:0] num_mag;
        logic [WORD_W-1:0] den_mag;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] rem;
        logic              num_neg;
        logic              den_neg;
        rsp_t              res;
        res.read_value = '0;
        num_neg = op.rs_value[WORD_W-1];
        den_neg = op.rt_value[WORD_W-1];
        case (op.kind)
            KIND_MULT:
            begin
                product = $signed({{WORD_W{num_neg}}, op.rs_value})
                        * $signed({{WORD_W{den_neg}}, op.rt_value});
                hi_model = product[63:32];
                lo_model = product[31:0];
            end
            KIND_MULTU:
            begin
                product = {32'b0, op.rs_value} * {32'b0, op.rt_value};
                hi_model = product[63:32];
                lo_model = product[31:0];
            end
            KIND_DIV:
            begin
                if (op.rt_value == '0)
                begin
                    // zero divisor: dividend to HI, LO depends on dividend sign
                    hi_model = op.rs_value;
                    lo_model = num_neg ? 32'd1 : ALL_ONES;
                end
                else if (op.rs_value == SIGN_WORD && op.rt_value == ALL_ONES)
                begin
                    // most negative over minus one overflows
                    hi_model = '0;
                    lo_model = SIGN_WORD;
                end
                else
                begin
                    num_mag  = num_neg ? -op.rs_value : op.rs_value;
                    den_mag  = den_neg ? -op.rt_value : op.rt_value;
                    quo      = num_mag / den_mag;
                    rem      = num_mag % den_mag;
                    lo_model = (num_neg ^ den_neg) ? -quo : quo;
                    hi_model = num_neg ? -rem : rem;
                end
            end
            KIND_DIVU:
            begin
                if (op.rt_value == '0)
                begin
                    hi_model = op.rs_value;
                    lo_model = ALL_ONES;
                end
                else
                begin
                    hi_model = op.rs_value % op.rt_value;
                    lo_model = op.rs_value / op.rt_value;
                end
            end
            KIND_MTHI: hi_model = op.rs_value;
            KIND_MTLO: lo_model = op.rs_value;
            KIND_MFHI: res.read_value = hi_model;
            default:   res.read_value = lo_model;
        endcase
        res.hi_after = hi_model;
        res.lo_after = lo_model;
        return res;
    endfunction

    // operand mix: full random, corner values, small magnitudes, powers of two, shifted random
    function automatic logic [WORD_W-1:0] rand_operand();
        logic [WORD_W-1:0] mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom();
            5:
            begin
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return ALL_ONES;
                    3:       return SIGN_WORD;
                    4:       return MAX_POS;
                    default: return 32'd2;
                endcase
            end
            6: return $urandom_range(0, 255);
            7:
            begin
                mag = $urandom_range(1, 255);
                return -mag;
            end
            8: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom() >> $urandom_range(1, 31);
        endcase
    endfunction

    // idle length between requests or response stalls: mostly short, a few long
    function automatic int pick_idle(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic queue_op(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] rs,
                            logic [WORD_W-1:0] rt, bit drain_first = 1'b0);
        pending_op_t p;
        p.op.kind     = kind;
        p.op.rs_value = rs;
        p.op.rt_value = rt;
        p.drain_first = drain_first;
        pending_ops.push_back(p);
    endtask

    task automatic note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // request driver: pops pending operations, predicts on each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        pending_op_t pend;
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
            send_gap       <= 0;
            hi_model       = '0;
            lo_model       = '0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_results.push_back(hilo_predict(req_if.payload));
                accepted_count++;
            end
            if (req_if.valid && !req_if.ready)
            begin
                // hold the offered transaction
            end
            else if (send_gap != 0)
            begin
                req_if.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain_first && expected_results.size() != 0))
            begin
                pend = pending_ops.pop_front();
                req_if.valid   <= 1'b1;
                req_if.payload <= pend.op;
                send_gap       <= pick_idle((accepted_count / 100) % 5 == 4);
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response monitor: random stalls, compare against oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                checked_count++;
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("unexpected result rd=%h hi=%h lo=%h",
                        rsp_if.payload.read_value, rsp_if.payload.hi_after,
                        rsp_if.payload.lo_after));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_if.payload.read_value !== want.read_value)
                        note_failure($sformatf("read_value exp %h got %h",
                            want.read_value, rsp_if.payload.read_value));
                    if (rsp_if.payload.hi_after !== want.hi_after)
                        note_failure($sformatf("hi_after exp %h got %h",
                            want.hi_after, rsp_if.payload.hi_after));
                    if (rsp_if.payload.lo_after !== want.lo_after)
                        note_failure($sformatf("lo_after exp %h got %h",
                            want.lo_after, rsp_if.payload.lo_after));
                end
            end
            if (stall_left != 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left <= pick_idle((checked_count / 130) % 5 == 2);
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int r;
        rst_n = 1'b0;

        // directed corners
        queue_op(KIND_MFHI,  $urandom(), $urandom());
        queue_op(KIND_MFLO,  $urandom(), $urandom());
        queue_op(KIND_MULT,  SIGN_WORD, SIGN_WORD);
        queue_op(KIND_MULT,  ALL_ONES,  ALL_ONES);
        queue_op(KIND_MULT,  MAX_POS,   SIGN_WORD);
        queue_op(KIND_MULTU, ALL_ONES,  ALL_ONES);
        queue_op(KIND_MULTU, SIGN_WORD, 32'd0);
        queue_op(KIND_DIV,   32'd100,   32'd0);
        queue_op(KIND_DIV,   SIGN_WORD, 32'd0);
        queue_op(KIND_DIV,   32'd0,     32'd0);
        queue_op(KIND_DIV,   SIGN_WORD, ALL_ONES);
        queue_op(KIND_DIV,   -32'd7,    32'd2);
        queue_op(KIND_DIV,   32'd7,     -32'd2);
        queue_op(KIND_DIV,   -32'd7,    -32'd2);
        queue_op(KIND_DIVU,  ALL_ONES,  32'd0);
        queue_op(KIND_DIVU,  ALL_ONES,  32'd3);
        queue_op(KIND_DIVU,  32'd5,     ALL_ONES);
        queue_op(KIND_MTHI,  ALL_ONES,  $urandom());
        queue_op(KIND_MTLO,  SIGN_WORD, $urandom());
        queue_op(KIND_MFHI,  $urandom(), $urandom());
        queue_op(KIND_MFLO,  $urandom(), $urandom());
        queue_op(KIND_MTHI,  32'd0,     ALL_ONES);
        queue_op(KIND_MFHI,  ALL_ONES,  ALL_ONES);

        // random operations, with a full drain now and then
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                queue_op(KIND_DIV, SIGN_WORD, ALL_ONES, i % 400 == 0);
            else
                queue_op(logic'($urandom_range(0, 7)) ? 3'($urandom_range(0, 7)) :
                         3'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                         i % 400 == 0);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
